[rtl/lfbp_pkg.sv]
`default_nettype none

package lfbp_pkg;

  localparam int STORE_BYTES_DEF = 1024;
  localparam int WORD_BITS_DEF   = 64;

  localparam int DATA_W    = 64;
  localparam int COUNT_W   = 4;
  localparam int CURSOR_W  = 14;
  localparam int MAX_BITS  = 8;
  localparam int ROW_W     = 64;
  localparam int WIN_W     = 2 * ROW_W;
  localparam int WIN_BYTES = WIN_W / 8;
  localparam int OFF_W     = 6;
  localparam int NB_W      = 7;
  localparam int VCNT_W    = 5;

  typedef enum logic [2:0] {
    MODE_WRITE_BITS = 3'd0,
    MODE_READ_BITS  = 3'd1,
    MODE_WRITE_WORD = 3'd2,
    MODE_READ_WORD  = 3'd3,
    MODE_APPEND     = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PAST_END = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ,
    OP_APPEND
  } op_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic [DATA_W-1:0]  data_in;
    logic [COUNT_W-1:0] bit_count;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    status_e             status;
    logic [CURSOR_W-1:0] cursor_out;
  } out_t;

  // per-transaction control handed from the check stage to the row datapath
  typedef struct packed {
    op_e                 op;
    status_e             status;
    logic [OFF_W-1:0]    offset;
    logic [NB_W-1:0]     nbits;
    logic [VCNT_W-1:0]   vcnt;
    logic                lo_odd;
    logic [CURSOR_W-1:0] cursor;
    logic [DATA_W-1:0]   data;
  } s1_t;

endpackage

`default_nettype wire

[rtl/lfbp_ram.sv]
`default_nettype none

module lfbp_ram #(
  parameter int DEPTH = 65,
  parameter int AW    = 7
) (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [AW-1:0]                  waddr_i,
  input  wire logic [lfbp_pkg::ROW_W-1:0]     wdata_i,
  input  wire logic                           re_i,
  input  wire logic [AW-1:0]                  raddr_i,
  output logic      [lfbp_pkg::ROW_W-1:0]     rdata_o
);

  logic [lfbp_pkg::ROW_W-1:0] mem_q [DEPTH];
  logic [lfbp_pkg::ROW_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/lfbp_ctrl.sv]
`default_nettype none

module lfbp_ctrl #(
  parameter int STORE_BYTES = lfbp_pkg::STORE_BYTES_DEF,
  parameter int WORD_BITS   = lfbp_pkg::WORD_BITS_DEF,
  parameter int BANK_AW     = 7
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire lfbp_pkg::in_t        in_data_i,
  output logic                      in_stall_o,
  input  wire logic                 advance_i,
  output logic                      accept_o,
  output logic      [BANK_AW-1:0]   rd_addr_even_o,
  output logic      [BANK_AW-1:0]   rd_addr_odd_o,
  output logic                      s1_valid_o,
  output lfbp_pkg::s1_t             s1_o,
  output logic      [BANK_AW-1:0]   s1_addr_even_o,
  output logic      [BANK_AW-1:0]   s1_addr_odd_o
);

  localparam int FIL_W   = $clog2(STORE_BYTES + 1);
  localparam int POS_W   = FIL_W + 3;
  localparam int POS_W1  = POS_W + 1;
  localparam int RIDX_W  = POS_W - 6;
  localparam int CW      = lfbp_pkg::CURSOR_W;
  localparam int NB_W    = lfbp_pkg::NB_W;
  localparam int OFF_W   = lfbp_pkg::OFF_W;
  localparam int VCNT_W  = lfbp_pkg::VCNT_W;
  localparam int COUNT_W = lfbp_pkg::COUNT_W;

  localparam logic [POS_W:0]       CAP_BITS  = POS_W1'(8 * STORE_BYTES);
  localparam logic [FIL_W-1:0]     CAP_BYTES = FIL_W'(STORE_BYTES);
  localparam logic [NB_W-1:0]      WORD_N    = NB_W'(WORD_BITS);
  localparam logic [COUNT_W-1:0]   MAX_CNT   = COUNT_W'(lfbp_pkg::MAX_BITS);
  localparam logic [FIL_W-1:0]     WIN_LIM   = FIL_W'(lfbp_pkg::WIN_BYTES);

  logic [POS_W-1:0]   cursor_q, cursor_d;
  logic [FIL_W-1:0]   filled_q, filled_d;
  logic               s1_valid_q;
  lfbp_pkg::s1_t      s1_q, s1_d;
  logic [BANK_AW-1:0] addr_even_q, addr_odd_q;
  logic [BANK_AW-1:0] addr_even, addr_odd;

  logic [COUNT_W-1:0] cnt;
  logic [NB_W-1:0]    nbits;
  logic [POS_W:0]     sum;
  logic [POS_W:0]     filled_bits;
  logic [POS_W:0]     grow_sum;
  logic [FIL_W-1:0]   grow_bytes;
  logic [POS_W-1:0]   pos;
  logic [RIDX_W-1:0]  ridx;
  logic [FIL_W-1:0]   vdiff;
  logic               accept;

  assign in_stall_o = s1_valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cnt = (in_data_i.bit_count > MAX_CNT) ? MAX_CNT : in_data_i.bit_count;

    case (in_data_i.mode)
      lfbp_pkg::MODE_WRITE_BITS, lfbp_pkg::MODE_READ_BITS: begin
        nbits = NB_W'(cnt);
      end
      lfbp_pkg::MODE_WRITE_WORD, lfbp_pkg::MODE_READ_WORD: begin
        nbits = WORD_N;
      end
      default: begin
        nbits = '0;
      end
    endcase

    sum         = {1'b0, cursor_q} + POS_W1'(nbits);
    filled_bits = {1'b0, filled_q, 3'b000};
    grow_sum    = sum + POS_W1'(7);
    grow_bytes  = grow_sum[POS_W-1:3];

    pos  = (in_data_i.mode == lfbp_pkg::MODE_APPEND) ? {filled_q, 3'b000} : cursor_q;
    ridx = pos[POS_W-1:6];

    addr_odd  = BANK_AW'(ridx >> 1);
    addr_even = BANK_AW'((ridx >> 1) + RIDX_W'(ridx[0]));

    vdiff = filled_q - {ridx, 3'b000};

    cursor_d = cursor_q;
    filled_d = filled_q;

    s1_d.op     = lfbp_pkg::OP_NONE;
    s1_d.status = lfbp_pkg::ST_OK;
    s1_d.offset = pos[OFF_W-1:0];
    s1_d.nbits  = nbits;
    s1_d.vcnt   = (vdiff > WIN_LIM) ? VCNT_W'(lfbp_pkg::WIN_BYTES) : vdiff[VCNT_W-1:0];
    s1_d.lo_odd = ridx[0];
    s1_d.data   = in_data_i.data_in;

    case (in_data_i.mode)
      lfbp_pkg::MODE_WRITE_BITS, lfbp_pkg::MODE_WRITE_WORD: begin
        if (sum <= CAP_BITS) begin
          s1_d.op  = lfbp_pkg::OP_WRITE;
          cursor_d = sum[POS_W-1:0];
          if (grow_bytes > filled_q) begin
            filled_d = grow_bytes;
          end
        end else begin
          s1_d.status = lfbp_pkg::ST_FULL;
        end
      end
      lfbp_pkg::MODE_READ_BITS, lfbp_pkg::MODE_READ_WORD: begin
        if (sum <= filled_bits) begin
          s1_d.op  = lfbp_pkg::OP_READ;
          cursor_d = sum[POS_W-1:0];
        end else begin
          s1_d.status = lfbp_pkg::ST_PAST_END;
        end
      end
      lfbp_pkg::MODE_APPEND: begin
        if (filled_q < CAP_BYTES) begin
          s1_d.op  = lfbp_pkg::OP_APPEND;
          filled_d = filled_q + FIL_W'(1);
        end else begin
          s1_d.status = lfbp_pkg::ST_FULL;
        end
      end
      default: begin
      end
    endcase

    s1_d.cursor = CW'(cursor_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q   <= '0;
      filled_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cursor_q <= cursor_d;
        filled_q <= filled_d;
      end
      s1_valid_q <= accept || (s1_valid_q && !advance_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q        <= s1_d;
      addr_even_q <= addr_even;
      addr_odd_q  <= addr_odd;
    end
  end

  assign accept_o       = accept;
  assign rd_addr_even_o = addr_even;
  assign rd_addr_odd_o  = addr_odd;
  assign s1_valid_o     = s1_valid_q;
  assign s1_o           = s1_q;
  assign s1_addr_even_o = addr_even_q;
  assign s1_addr_odd_o  = addr_odd_q;

endmodule

`default_nettype wire

[rtl/lfbp_datapath.sv]
`default_nettype none

module lfbp_datapath #(
  parameter int BANK_AW = 7
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic                         s1_valid_i,
  input  wire lfbp_pkg::s1_t                s1_i,
  input  wire logic [BANK_AW-1:0]           s1_addr_even_i,
  input  wire logic [BANK_AW-1:0]           s1_addr_odd_i,
  input  wire logic [lfbp_pkg::ROW_W-1:0]   rd_even_i,
  input  wire logic [lfbp_pkg::ROW_W-1:0]   rd_odd_i,
  output logic                              advance_o,
  output logic                              we_o,
  output logic      [lfbp_pkg::ROW_W-1:0]   wr_even_o,
  output logic      [lfbp_pkg::ROW_W-1:0]   wr_odd_o,
  output logic                              out_valid_o,
  output lfbp_pkg::out_t                    out_data_o,
  input  wire logic                         out_stall_i
);

  localparam int ROW_W  = lfbp_pkg::ROW_W;
  localparam int WIN_W  = lfbp_pkg::WIN_W;
  localparam int DATA_W = lfbp_pkg::DATA_W;
  localparam int VCNT_W = lfbp_pkg::VCNT_W;

  logic                 out_valid_q;
  lfbp_pkg::out_t       out_q;
  logic                 fwd_hit_q;
  logic [BANK_AW-1:0]   fwd_addr_even_q, fwd_addr_odd_q;
  logic [ROW_W-1:0]     fwd_even_q, fwd_odd_q;

  logic [ROW_W-1:0]     row_even, row_odd, row_lo, row_hi;
  logic [WIN_W-1:0]     win, nmask, shifted, keep, ins, wr_win, app_win, new_win;
  logic [DATA_W-1:0]    rd_data;
  logic                 advance, we;

  always_comb begin
    row_even = (fwd_hit_q && (fwd_addr_even_q == s1_addr_even_i)) ? fwd_even_q : rd_even_i;
    row_odd  = (fwd_hit_q && (fwd_addr_odd_q == s1_addr_odd_i)) ? fwd_odd_q : rd_odd_i;
    row_lo   = s1_i.lo_odd ? row_odd : row_even;
    row_hi   = s1_i.lo_odd ? row_even : row_odd;
    win      = {row_hi, row_lo};

    nmask   = (WIN_W'(1) << s1_i.nbits) - WIN_W'(1);
    shifted = win >> s1_i.offset;
    rd_data = shifted[DATA_W-1:0] & nmask[DATA_W-1:0];

    // bytes at or past the filled end count as zero
    for (int j = 0; j < lfbp_pkg::WIN_BYTES; j++) begin
      keep[j*8 +: 8] = (VCNT_W'(j) < s1_i.vcnt) ? 8'hFF : 8'h00;
    end

    ins     = (WIN_W'(s1_i.data) & nmask) << s1_i.offset;
    wr_win  = (win & keep) | ins;
    app_win = (win & ~(WIN_W'(8'hFF) << s1_i.offset)) | (WIN_W'(s1_i.data[7:0]) << s1_i.offset);
    new_win = (s1_i.op == lfbp_pkg::OP_APPEND) ? app_win : wr_win;

    wr_even_o = s1_i.lo_odd ? new_win[WIN_W-1:ROW_W] : new_win[ROW_W-1:0];
    wr_odd_o  = s1_i.lo_odd ? new_win[ROW_W-1:0] : new_win[WIN_W-1:ROW_W];

    advance = s1_valid_i && (!out_valid_q || !out_stall_i);
    we      = advance && ((s1_i.op == lfbp_pkg::OP_WRITE) || (s1_i.op == lfbp_pkg::OP_APPEND));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      fwd_hit_q   <= 1'b0;
    end else begin
      out_valid_q <= advance || (out_valid_q && out_stall_i);
      if (accept_i) begin
        fwd_hit_q <= we;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.read_data  <= (s1_i.op == lfbp_pkg::OP_READ) ? rd_data : '0;
      out_q.status     <= s1_i.status;
      out_q.cursor_out <= s1_i.cursor;
    end
    if (we) begin
      fwd_addr_even_q <= s1_addr_even_i;
      fwd_addr_odd_q  <= s1_addr_odd_i;
      fwd_even_q      <= wr_even_o;
      fwd_odd_q       <= wr_odd_o;
    end
  end

  assign advance_o   = advance;
  assign we_o        = we;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/lsb_first_bit_packer.sv]
`default_nettype none

// LSB-first bit packer and unpacker over a byte store with one shared bit cursor.
// Each transaction writes or reads up to 8 bits, writes or reads one word, or
// appends a raw byte at the filled end; a read past the filled end reports
// past-end and a write past capacity reports full, and neither changes state.
// The store lives in two 64-bit-row memories (even and odd rows), so any
// operation touches at most one row of each bank: one read at acceptance and
// one write back from the check stage. The block takes one transaction per cycle
// unless stalled and registers it in the check and output stages; a row written
// back in the same cycle as the next read is forwarded. Input stall rises only
// while a finished result waits on a stalled output. No clearing pass runs after
// reset: bytes past the filled end are treated as zero when the store grows.

module lsb_first_bit_packer #(
  parameter int STORE_BYTES = lfbp_pkg::STORE_BYTES_DEF,
  parameter int WORD_BITS   = lfbp_pkg::WORD_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire lfbp_pkg::in_t   in_data_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output lfbp_pkg::out_t       out_data_o,
  input  wire logic            out_stall_i
);

  localparam int BANK_DEPTH = ((STORE_BYTES / 8) + 1) / 2 + 1;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  logic                         accept, advance, we, s1_valid;
  lfbp_pkg::s1_t                s1;
  logic [BANK_AW-1:0]           rd_addr_even, rd_addr_odd, s1_addr_even, s1_addr_odd;
  logic [lfbp_pkg::ROW_W-1:0]   rd_even, rd_odd, wr_even, wr_odd;

  lfbp_ctrl #(
    .STORE_BYTES (STORE_BYTES),
    .WORD_BITS   (WORD_BITS),
    .BANK_AW     (BANK_AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_data_i      (in_data_i),
    .in_stall_o     (in_stall_o),
    .advance_i      (advance),
    .accept_o       (accept),
    .rd_addr_even_o (rd_addr_even),
    .rd_addr_odd_o  (rd_addr_odd),
    .s1_valid_o     (s1_valid),
    .s1_o           (s1),
    .s1_addr_even_o (s1_addr_even),
    .s1_addr_odd_o  (s1_addr_odd)
  );

  lfbp_ram #(
    .DEPTH (BANK_DEPTH),
    .AW    (BANK_AW)
  ) u_ram_even (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s1_addr_even),
    .wdata_i (wr_even),
    .re_i    (accept),
    .raddr_i (rd_addr_even),
    .rdata_o (rd_even)
  );

  lfbp_ram #(
    .DEPTH (BANK_DEPTH),
    .AW    (BANK_AW)
  ) u_ram_odd (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s1_addr_odd),
    .wdata_i (wr_odd),
    .re_i    (accept),
    .raddr_i (rd_addr_odd),
    .rdata_o (rd_odd)
  );

  lfbp_datapath #(
    .BANK_AW (BANK_AW)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .s1_valid_i     (s1_valid),
    .s1_i           (s1),
    .s1_addr_even_i (s1_addr_even),
    .s1_addr_odd_i  (s1_addr_odd),
    .rd_even_i      (rd_even),
    .rd_odd_i       (rd_odd),
    .advance_o      (advance),
    .we_o           (we),
    .wr_even_o      (wr_even),
    .wr_odd_o       (wr_odd),
    .out_valid_o    (out_valid_o),
    .out_data_o     (out_data_o),
    .out_stall_i    (out_stall_i)
  );

endmodule

`default_nettype wire

[rtl/lfbp_checker.sv]
`default_nettype none

module lfbp_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire lfbp_pkg::in_t   in_data_i,
  input wire logic            in_stall_o,
  input wire logic            out_valid_o,
  input wire lfbp_pkg::out_t  out_data_o,
  input wire logic            out_stall_i
);

  logic [lfbp_pkg::CURSOR_W-1:0] last_cursor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cursor_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      last_cursor_q <= out_data_o.cursor_out;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  a_error_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != lfbp_pkg::ST_OK) |-> out_data_o.read_data == '0)
    else $error("failed transaction returned data");

  a_error_keeps_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != lfbp_pkg::ST_OK)
      |-> out_data_o.cursor_out == last_cursor_q)
    else $error("failed transaction moved the cursor");

  a_input_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !$isunknown(in_data_i.mode))
    else $error("accepted transaction with unknown mode");

endmodule

bind lsb_first_bit_packer lfbp_checker u_lfbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_data_i   (in_data_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_data_o  (out_data_o),
  .out_stall_i (out_stall_i)
);

`default_nettype wire
